[rtl/awf_pkg.sv]
// Shared types and constants for the almost-worst-fit bin packer.
// Used by awf_ctrl, awf_dp and almost_worst_fit_bin_packing; no dependencies.
`default_nettype none

package awf_pkg;

    localparam int MAX_BINS_DEF   = 64;
    localparam int SIZE_WIDTH_DEF = 16;

    localparam logic [2:0]  ADDR_BIN_CAPACITY = 3'd0;
    localparam logic [15:0] CAP_RESET         = 16'd100;

    localparam logic [1:0] ST_PLACED   = 2'd0;
    localparam logic [1:0] ST_OVERSIZE = 2'd1;
    localparam logic [1:0] ST_NO_BIN   = 2'd2;

    typedef struct packed {
        logic start;
        logic scan;
        logic decide;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/awf_ctrl.sv]
// Sequencer for the bin packer: accept, scan of open bins, placement.
// Depends on awf_pkg for the command and status structs.
`default_nettype none

module awf_ctrl import awf_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    output t_ctrl_cmd      o_cmd,
    input  wire t_dp_sts   i_sts
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_ready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/awf_dp.sv]
// Datapath for the bin packer: free-space memory, scan trackers, placement, result register.
// Depends on awf_pkg for status codes and the command and status structs.
`default_nettype none

module awf_dp import awf_pkg::*; #(
    parameter int MAX_BINS   = MAX_BINS_DEF,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctrl_cmd             i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic [15:0]           i_item_size,
    input  wire logic [SIZE_WIDTH-1:0] i_bin_capacity,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [5:0]                 o_bin_index,
    output logic                       o_opened_new,
    output logic                       o_bin_now_full,
    output logic [1:0]                 o_status,
    output logic [6:0]                 o_bins_in_use
);

    localparam int IW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);

    logic [SIZE_WIDTH-1:0] r_mem [MAX_BINS];

    logic [SIZE_WIDTH-1:0] r_item;
    logic                  r_over;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_issue;
    logic                  r_rvalid;
    logic [IW-1:0]         r_ridx;
    logic [SIZE_WIDTH-1:0] r_rdata;

    logic                  r_have1;
    logic                  r_have2;
    logic [IW-1:0]         r_idx1;
    logic [IW-1:0]         r_idx2;
    logic [SIZE_WIDTH-1:0] r_val1;
    logic [SIZE_WIDTH-1:0] r_val2;

    logic                  r_out_valid;

    logic                  issue_ok;
    logic                  need_new;
    logic                  no_room;
    logic                  use2;
    logic [IW-1:0]         wr_idx;
    logic [SIZE_WIDTH-1:0] sel_val;
    logic [SIZE_WIDTH-1:0] new_free;
    logic [1:0]            res_status;
    logic                  placed;
    logic [SIZE_WIDTH-1:0] item_in;

    assign item_in  = SIZE_WIDTH'(i_item_size);
    assign issue_ok = r_issue < r_count;

    assign need_new   = !r_have1 || (r_val1 < r_item);
    assign no_room    = r_count == CW'(MAX_BINS);
    assign use2       = r_have2 && (r_val2 >= r_item);
    assign sel_val    = use2 ? r_val2 : r_val1;
    assign wr_idx     = need_new ? r_count[IW-1:0] : (use2 ? r_idx2 : r_idx1);
    assign new_free   = need_new ? (i_bin_capacity - r_item) : (sel_val - r_item);
    assign res_status = r_over ? ST_OVERSIZE :
                        ((need_new && no_room) ? ST_NO_BIN : ST_PLACED);
    assign placed     = res_status == ST_PLACED;

    assign o_sts.scan_done = !issue_ok && !r_rvalid;
    assign o_sts.out_free  = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && issue_ok) begin
            r_rdata <= r_mem[r_issue[IW-1:0]];
        end
        if (i_cmd.decide && placed) begin
            r_mem[wr_idx] <= new_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_item <= item_in;
            r_over <= item_in > i_bin_capacity;
        end
        if (i_cmd.scan && issue_ok) begin
            r_ridx <= r_issue[IW-1:0];
        end
        if (r_rvalid && (r_rdata != '0)) begin
            if (!r_have1 || (r_rdata > r_val1)) begin
                if (r_have1) begin
                    r_idx2 <= r_idx1;
                    r_val2 <= r_val1;
                end
                r_idx1 <= r_ridx;
                r_val1 <= r_rdata;
            end else if (!r_have2 || (r_rdata > r_val2)) begin
                r_idx2 <= r_ridx;
                r_val2 <= r_rdata;
            end
        end
        if (i_cmd.decide) begin
            o_bin_index    <= placed ? 6'(wr_idx) : 6'd0;
            o_opened_new   <= placed && need_new;
            o_bin_now_full <= placed && (new_free == '0);
            o_status       <= res_status;
            o_bins_in_use  <= (placed && need_new) ? 7'(r_count + CW'(1)) : 7'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_issue     <= '0;
            r_rvalid    <= 1'b0;
            r_have1     <= 1'b0;
            r_have2     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rvalid <= i_cmd.scan && issue_ok;
            if (i_cmd.start) begin
                r_issue <= '0;
                r_have1 <= 1'b0;
                r_have2 <= 1'b0;
            end else begin
                if (i_cmd.scan && issue_ok) begin
                    r_issue <= r_issue + CW'(1);
                end
                if (r_rvalid && (r_rdata != '0)) begin
                    if (!r_have1 || (r_rdata > r_val1)) begin
                        r_have1 <= 1'b1;
                        if (r_have1) begin
                            r_have2 <= 1'b1;
                        end
                    end else begin
                        r_have2 <= 1'b1;
                    end
                end
            end
            if (i_cmd.decide && placed && need_new) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.decide) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/almost_worst_fit_bin_packing.sv]
// Online almost-worst-fit bin packer. Each input transaction carries one item size; the
// result transaction names the bin that took it, or flags an oversize item or a lack of bins.
// After acceptance the item passes the scan and the decide states, and its result is offered
// from the output register. The time per item grows with the number of open bins, as it is
// set by the single read port of the free-space memory. The scan walks it one open bin per
// cycle to find the emptiest and second emptiest bins. One item is in work at a time. The next
// is accepted while the previous result still waits in the output register. The placement
// holds until that result is taken. bin_capacity (APB, byte address 0) applies to bins opened
// after the write.
// Depends on awf_pkg, awf_ctrl and awf_dp.
`default_nettype none

module almost_worst_fit_bin_packing import awf_pkg::*; #(
    parameter int MAX_BINS   = MAX_BINS_DEF,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_item_size,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [5:0]       o_bin_index,
    output logic             o_opened_new,
    output logic             o_bin_now_full,
    output logic [1:0]       o_status,
    output logic [6:0]       o_bins_in_use
);

    logic [SIZE_WIDTH-1:0] r_cap;
    t_ctrl_cmd             cmd;
    t_dp_sts               sts;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BIN_CAPACITY) ? 32'(r_cap) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= SIZE_WIDTH'(CAP_RESET);
        end else if (psel && penable && pwrite && (paddr == ADDR_BIN_CAPACITY)) begin
            r_cap <= SIZE_WIDTH'(pwdata[15:0]);
        end
    end

    awf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    awf_dp #(
        .MAX_BINS   (MAX_BINS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_item_size    (i_item_size),
        .i_bin_capacity (r_cap),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_bin_index    (o_bin_index),
        .o_opened_new   (o_opened_new),
        .o_bin_now_full (o_bin_now_full),
        .o_status       (o_status),
        .o_bins_in_use  (o_bins_in_use)
    );

endmodule

`default_nettype wire

[tb/tb_almost_worst_fit_bin_packing.sv]
// Self-checking testbench for almost_worst_fit_bin_packing: drives item sizes and APB capacity
// writes, predicts every placement with a scoreboard class and compares results field by field.
// Depends on awf_pkg and the almost_worst_fit_bin_packing RTL.
`timescale 1ns / 100ps

module tb_almost_worst_fit_bin_packing;
    import awf_pkg::*;

    typedef struct packed {
        logic [5:0] bin_index;
        logic       opened_new;
        logic       bin_now_full;
        logic [1:0] status;
        logic [6:0] bins_in_use;
    } placement_t;

    class bin_packing_scoreboard;
        logic [15:0] free_space [MAX_BINS_DEF];
        int unsigned open_count;
        logic [15:0] capacity;
        placement_t  expected_placements [$];
        int          mismatches;

        function new();
            foreach (free_space[i]) free_space[i] = '0;
            open_count = 0;
            capacity   = CAP_RESET;
            mismatches = 0;
        endfunction

        function void set_capacity(logic [15:0] value);
            capacity = value;
        endfunction

        function int pending();
            return expected_placements.size();
        endfunction

        function placement_t predict_placement(logic [15:0] item);
            placement_t  r;
            int unsigned first, second, chosen;
            bit          have_first, have_second;
            logic [15:0] f;
            r = '0;
            first = 0;
            second = 0;
            chosen = 0;
            have_first = 0;
            have_second = 0;
            r.status = ST_PLACED;
            if (item > capacity) begin
                r.status = ST_OVERSIZE;
            end else begin
                for (int i = 0; i < open_count; i++) begin
                    f = free_space[i];
                    if (f == 0) continue;
                    if (!have_first || f > free_space[first]) begin
                        if (have_first) begin
                            second = first;
                            have_second = 1;
                        end
                        first = i;
                        have_first = 1;
                    end else if (!have_second || f > free_space[second]) begin
                        second = i;
                        have_second = 1;
                    end
                end
                if (!have_first || free_space[first] < item) begin
                    if (open_count >= MAX_BINS_DEF) begin
                        r.status = ST_NO_BIN;
                    end else begin
                        chosen = open_count;
                        free_space[chosen] = capacity - item;
                        open_count++;
                        r.opened_new = 1'b1;
                    end
                end else begin
                    if (have_second && free_space[second] >= item)
                        chosen = second;
                    else
                        chosen = first;
                    free_space[chosen] = free_space[chosen] - item;
                end
                if (r.status == ST_PLACED && free_space[chosen] == 0)
                    r.bin_now_full = 1'b1;
                if (r.status == ST_PLACED)
                    r.bin_index = chosen[5:0];
            end
            r.bins_in_use = open_count[6:0];
            return r;
        endfunction

        function void note_item(logic [15:0] item);
            expected_placements.insert(expected_placements.size(), predict_placement(item));
        endfunction

        task report(string what);
            mismatches++;
            $display("%0t mismatch: %s", $realtime, what);
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(placement_t got);
            placement_t want;
            if (expected_placements.size() == 0) begin
                report($sformatf("unexpected result transaction bin %0d status %0d",
                                 got.bin_index, got.status));
                return;
            end
            want = expected_placements.pop_front();
            compare_field("bin_index", got.bin_index, want.bin_index);
            compare_field("opened_new", got.opened_new, want.opened_new);
            compare_field("bin_now_full", got.bin_now_full, want.bin_now_full);
            compare_field("status", got.status, want.status);
            compare_field("bins_in_use", got.bins_in_use, want.bins_in_use);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_item_size;
    logic        o_valid;
    logic        i_ready;
    logic [5:0]  o_bin_index;
    logic        o_opened_new;
    logic        o_bin_now_full;
    logic [1:0]  o_status;
    logic [6:0]  o_bins_in_use;

    bin_packing_scoreboard sb = new();
    logic [15:0]           capacity_setting = CAP_RESET;
    bit                    idle_on = 1'b1;
    int                    stall_left = 0;

    almost_worst_fit_bin_packing DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_item_size    (i_item_size),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_bin_index    (o_bin_index),
        .o_opened_new   (o_opened_new),
        .o_bin_now_full (o_bin_now_full),
        .o_status       (o_status),
        .o_bins_in_use  (o_bins_in_use)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic set_capacity(input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BIN_CAPACITY;
        pwdata  <= {16'b0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {16'b0, value})
            sb.report($sformatf("bin_capacity read %0h expected %0h", prdata, value));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_capacity(value);
        capacity_setting = value;
    endtask

    task automatic send_item(input logic [15:0] size);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_item_size <= size;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_item(size);
        @(negedge i_clk);
    endtask

    task automatic drain_placements();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_item_size(input logic [15:0] cap);
        int unsigned pick, small_max;
        pick = $urandom_range(0, 99);
        small_max = (cap / 6 > 0) ? cap / 6 : 1;
        if (pick < 70)
            return 16'($urandom_range(1, small_max));
        else if (pick < 82)
            return 16'($urandom_range(1, (cap > 0) ? cap : 1));
        else if (pick < 90)
            return (cap < 16'hFFFF) ? 16'($urandom_range(cap + 1, 16'hFFFF)) : 16'hFFFF;
        else
            return 16'($urandom_range(1, 16'hFFFF));
    endfunction

    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_bin_index, o_opened_new, o_bin_now_full, o_status,
                             o_bins_in_use});
    end

    initial begin
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_valid     = 1'b0;
        i_item_size = '0;
        i_ready     = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_capacity(16'd100);
        send_item(16'd100);
        send_item(16'd101);
        send_item(16'hFFFF);
        send_item(16'd1);
        send_item(16'd0);
        send_item(16'd50);
        send_item(16'd60);
        send_item(16'd30);
        send_item(16'd49);
        send_item(16'd10);
        drain_placements();

        set_capacity(16'd0);
        send_item(16'd1);
        send_item(16'd0);
        drain_placements();

        set_capacity(16'hFFFF);
        send_item(16'hFFFF);
        send_item(16'd1);
        send_item(16'd32768);
        send_item(16'd32767);
        drain_placements();

        set_capacity(16'd1);
        send_item(16'd1);
        send_item(16'd0);
        send_item(16'd2);
        drain_placements();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_capacity(16'hFFFF);
                1: set_capacity(16'($urandom_range(2, 5000)));
                2: set_capacity(16'($urandom_range(50, 300)));
                default: begin
                    idle_on = 1'b0;
                    set_capacity(16'd1);
                end
            endcase
            repeat (225) send_item(pick_item_size(capacity_setting));
            drain_placements();
        end

        repeat (80) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/awf_pkg.sv
rtl/awf_ctrl.sv
rtl/awf_dp.sv
rtl/almost_worst_fit_bin_packing.sv
tb/tb_almost_worst_fit_bin_packing.sv
